@@ src/plc_pkg.sv @@
// Shared constants and types for the piecewise-linear calibration unit.
// Used by the top level and by its port checker; depends on nothing else.
package plc_pkg;

    localparam int MAX_POINTS = 16;
    localparam int PTR_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W     = PTR_W + 1;
    localparam int MEM_DEPTH  = 2 << PTR_W;

    localparam int CFG_W      = 5;
    localparam int VAL_W      = 16;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int DIV_BITS   = 2;
    localparam int DIV_ITER   = PROD_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_ITER);

    localparam int S_TDATA_W  = 72;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 3;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic REG_AC_POINTS = 1'b0;
    localparam logic REG_DC_POINTS = 1'b1;

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_TO_DAC  = 2'd1;
    localparam logic [1:0] ACT_TO_VOLT = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_WRITTEN   = 3'd1;
    localparam logic [2:0] ST_ZERO_DIV  = 3'd2;
    localparam logic [2:0] ST_SATURATED = 3'd3;
    localparam logic [2:0] ST_FEW       = 3'd4;

    typedef struct packed {
        logic [VAL_W-1:0] adc;
        logic [VAL_W-1:0] dac;
        logic [VAL_W-1:0] volt;
    } cal_point_t;

endpackage

@@ src/piecewise_linear_calibration_unit.sv @@
// Piecewise-linear calibration unit: point table, serial segment search,
// shared multiplier and two-bit-per-cycle divider. Depends on plc_pkg.
//
//  Channel  Direction  Ports                     Contents
//  s_       in         s_tvalid/s_tready         point write or conversion request
//  m_       out        m_tvalid/m_tready         converted value and status
//  APB      in/out     psel..pready              points-in-use registers
//
// A write, an action-3 request or a short-table query goes straight to done; a zero
// divisor ends in the search, and a full conversion passes through the search, multiply,
// divide and finish states. The search reads 1 to MAX_POINTS entries, one per cycle, and
// the divider retires two quotient bits per cycle. One request is in work at a time.
// A new request is taken while a finished result still waits on m_tready.
// Reset clears the control state and both registers; the table is not cleared.
module piecewise_linear_calibration_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_index, point_voltage, point_dac_code, point_adc_code, query_value
    input  logic [plc_pkg::S_TDATA_W-1:0]   s_tdata,
    // action, bank
    input  logic [plc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // converted_value
    output logic [plc_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic [plc_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [plc_pkg::PADDR_W-1:0]     paddr,
    input  logic [plc_pkg::PDATA_W-1:0]     pwdata,
    output logic [plc_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import plc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    cal_point_t             mem [MEM_DEPTH];

    logic [2:0]             state_reg, state_next;
    logic [CFG_W-1:0]       ac_points_reg, dc_points_reg;
    logic                   adc_in_reg, adc_in_next;
    logic                   bank_reg, bank_next;
    logic [VAL_W-1:0]       x_reg, x_next;
    logic [PTR_W-1:0]       i_reg, i_next;
    logic [PTR_W-1:0]       last_reg, last_next;
    logic [VAL_W-1:0]       lo_key_reg, lo_key_next;
    logic [VAL_W-1:0]       lo_res_reg, lo_res_next;
    logic [VAL_W-1:0]       mul_a_reg, mul_a_next;
    logic [VAL_W-1:0]       mul_b_reg, mul_b_next;
    logic                   neg_reg, neg_next;
    logic [VAL_W-1:0]       base_reg, base_next;
    logic [VAL_W-1:0]       div_reg, div_next;
    logic [PROD_W-1:0]      quot_reg, quot_next;
    logic [VAL_W-1:0]       rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VAL_W-1:0]       val_reg, val_next;
    logic [2:0]             stat_reg, stat_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]   m_tuser_reg, m_tuser_next;
    cal_point_t             rd_data_reg;

    logic                   s_accept;
    logic [1:0]             in_action;
    logic                   in_bank;
    logic [3:0]             in_index;
    cal_point_t             in_point;
    logic [VAL_W-1:0]       in_query;
    logic                   mem_we;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic [CNT_W-1:0]       n_points;
    logic [VAL_W-1:0]       rd_key;
    logic [VAL_W-1:0]       rd_res;
    logic [VAL_W-1:0]       div_rem;
    logic [PROD_W-1:0]      div_quot;
    logic signed [PROD_W+1:0] fin_q;
    logic signed [PROD_W+1:0] fin_sum;

    function automatic logic [CNT_W-1:0] sat_points(input logic [CFG_W-1:0] v);
        if (int'(v) > MAX_POINTS) begin
            return CNT_W'(MAX_POINTS);
        end
        return CNT_W'(v);
    endfunction

    assign in_action      = s_tuser[1:0];
    assign in_bank        = s_tuser[2];
    assign in_index       = s_tdata[3:0];
    assign in_point.volt  = s_tdata[19:4];
    assign in_point.dac   = s_tdata[35:20];
    assign in_point.adc   = s_tdata[51:36];
    assign in_query       = s_tdata[67:52];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DC_POINTS) ? PDATA_W'(dc_points_reg)
                                                : PDATA_W'(ac_points_reg);

    assign n_points = in_bank ? sat_points(dc_points_reg) : sat_points(ac_points_reg);
    assign wr_addr  = {in_bank, PTR_W'(in_index)};
    assign mem_we   = s_accept && (in_action == ACT_WRITE) && (int'(in_index) < MAX_POINTS);
    assign rd_addr  = (state_reg == S_IDLE) ? {in_bank, PTR_W'(0)}
                                            : {bank_reg, i_reg + PTR_W'(1)};
    assign rd_key   = adc_in_reg ? rd_data_reg.adc  : rd_data_reg.volt;
    assign rd_res   = adc_in_reg ? rd_data_reg.volt : rd_data_reg.dac;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= in_point;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        logic [VAL_W:0] r17;
        r17      = '0;
        div_rem  = rem_reg;
        div_quot = quot_reg;
        for (int k = 0; k < DIV_BITS; k++) begin
            r17      = {div_rem, div_quot[PROD_W-1]};
            div_quot = {div_quot[PROD_W-2:0], 1'b0};
            if (r17 >= {1'b0, div_reg}) begin
                div_rem     = VAL_W'(r17 - {1'b0, div_reg});
                div_quot[0] = 1'b1;
            end else begin
                div_rem = r17[VAL_W-1:0];
            end
        end
    end

    assign fin_q   = neg_reg ? -$signed({2'b00, quot_reg}) : $signed({2'b00, quot_reg});
    assign fin_sum = $signed({(PROD_W + 2 - VAL_W)'(0), base_reg}) + fin_q;

    always_comb begin
        state_next    = state_reg;
        adc_in_next   = adc_in_reg;
        bank_next     = bank_reg;
        x_next        = x_reg;
        i_next        = i_reg;
        last_next     = last_reg;
        lo_key_next   = lo_key_reg;
        lo_res_next   = lo_res_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        neg_next      = neg_reg;
        base_next     = base_reg;
        div_next      = div_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        val_next      = val_reg;
        stat_next     = stat_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    adc_in_next = (in_action == ACT_TO_VOLT);
                    bank_next   = in_bank;
                    x_next      = in_query;
                    i_next      = '0;
                    last_next   = PTR_W'(n_points - CNT_W'(1));
                    val_next    = '0;
                    unique case (in_action)
                        ACT_WRITE: begin
                            stat_next  = ST_WRITTEN;
                            state_next = S_DONE;
                        end
                        ACT_TO_DAC, ACT_TO_VOLT: begin
                            if (n_points < CNT_W'(2)) begin
                                stat_next  = ST_FEW;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_SEARCH;
                            end
                        end
                        ACT_NONE: begin
                            stat_next  = ST_OK;
                            state_next = S_DONE;
                        end
                        default: begin
                            stat_next  = ST_OK;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (i_reg == '0) begin
                    if (x_reg <= rd_key) begin
                        if (rd_key == '0) begin
                            val_next   = '0;
                            stat_next  = ST_ZERO_DIV;
                            state_next = S_DONE;
                        end else begin
                            mul_a_next = rd_res;
                            mul_b_next = x_reg;
                            neg_next   = 1'b0;
                            base_next  = '0;
                            div_next   = rd_key;
                            state_next = S_MUL;
                        end
                    end else begin
                        lo_key_next = rd_key;
                        lo_res_next = rd_res;
                        i_next      = i_reg + PTR_W'(1);
                    end
                end else if ((x_reg < rd_key) || (i_reg == last_reg)) begin
                    if (rd_key == lo_key_reg) begin
                        val_next   = '0;
                        stat_next  = ST_ZERO_DIV;
                        state_next = S_DONE;
                    end else begin
                        mul_a_next = (rd_res >= lo_res_reg) ? rd_res - lo_res_reg
                                                            : lo_res_reg - rd_res;
                        mul_b_next = x_reg - lo_key_reg;
                        div_next   = (rd_key >= lo_key_reg) ? rd_key - lo_key_reg
                                                            : lo_key_reg - rd_key;
                        neg_next   = (rd_res < lo_res_reg) ^ (rd_key < lo_key_reg);
                        base_next  = lo_res_reg;
                        state_next = S_MUL;
                    end
                end else begin
                    lo_key_next = rd_key;
                    lo_res_next = rd_res;
                    i_next      = i_reg + PTR_W'(1);
                end
            end
            S_MUL: begin
                quot_next  = mul_a_reg * mul_b_reg;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                quot_next = div_quot;
                rem_next  = div_rem;
                cnt_next  = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_ITER - 1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_sum < 0) begin
                    val_next  = '0;
                    stat_next = ST_SATURATED;
                end else if (fin_sum > $signed((PROD_W + 2)'(2 ** VAL_W - 1))) begin
                    val_next  = '1;
                    stat_next = ST_SATURATED;
                end else begin
                    val_next  = fin_sum[VAL_W-1:0];
                    stat_next = ST_OK;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = val_reg;
                    m_tuser_next  = stat_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            ac_points_reg <= '0;
            dc_points_reg <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (psel && penable && pwrite && pready) begin
                unique case (paddr[2])
                    REG_AC_POINTS: ac_points_reg <= pwdata[CFG_W-1:0];
                    REG_DC_POINTS: dc_points_reg <= pwdata[CFG_W-1:0];
                    default:       ac_points_reg <= ac_points_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        adc_in_reg  <= adc_in_next;
        bank_reg    <= bank_next;
        x_reg       <= x_next;
        i_reg       <= i_next;
        last_reg    <= last_next;
        lo_key_reg  <= lo_key_next;
        lo_res_reg  <= lo_res_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        neg_reg     <= neg_next;
        base_reg    <= base_next;
        div_reg     <= div_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        val_reg     <= val_next;
        stat_reg    <= stat_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

@@ src/plc_checker.sv @@
// Port-level checker for the piecewise-linear calibration unit and its bind.
// Depends on plc_pkg and on the top level's port list.
module plc_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [plc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [plc_pkg::M_TUSER_W-1:0]   m_tuser
);
    import plc_pkg::*;

    // Only one request is in work at a time.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in work");

    // Writes, zero divisors and short tables return a zero value.
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_WRITTEN || m_tuser == ST_ZERO_DIV
                      || m_tuser == ST_FEW)) |-> (m_tdata == '0))
        else $error("nonzero value with a no-result status");

    // A clamped result sits at one of the two rails.
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_SATURATED) |-> (m_tdata == '0 || m_tdata == '1))
        else $error("saturated status off the rails");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind piecewise_linear_calibration_unit plc_checker u_plc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
